FILE: rtl/cbc_pkg.sv
// cbc_pkg: region codes, stage records and helpers shared by the
// circle_box_contact pipeline. No dependencies.
package cbc_pkg;

	localparam logic [2:0] RG_RIGHT  = 3'd0;
	localparam logic [2:0] RG_BOTTOM = 3'd1;
	localparam logic [2:0] RG_LEFT   = 3'd2;
	localparam logic [2:0] RG_TOP    = 3'd3;
	localparam logic [2:0] RG_TR     = 3'd4;
	localparam logic [2:0] RG_BR     = 3'd5;
	localparam logic [2:0] RG_BL     = 3'd6;
	localparam logic [2:0] RG_TL     = 3'd7;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_BITS   = 26;

	// Geometry that rides along every stage.
	typedef struct packed {
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [30:0]        r;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic [2:0]         region;
		logic               degen;
		logic               corner;
		logic               nxneg;
		logic               nyneg;
	} geo_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		logic signed [31:0] res;
		if (v > 66'sd2147483647) res = 32'sh7FFFFFFF;
		else if (v < -66'sd2147483648) res = 32'sh80000000;
		else res = v[31:0];
		return res;
	endfunction

endpackage

FILE: rtl/circle_box_contact.sv
// circle_box_contact: circle against axis-aligned box contact generation,
// a pipeline that stalls as a whole. Depends on cbc_pkg.
//
// One query enters per clock and one result leaves per clock unless out_stall
// holds a valid result. The stages are classification and scaling (3), a
// bit-serial square root pipeline with one stage per result bit (32), a
// restoring divider with one stage per quotient bit for both normal
// components (26), then signed normal, radius products, circle point, dot
// products and output (5). A valid result held by out_stall freezes the
// whole pipeline and stalls the input; an empty output slot lets all advance.
module circle_box_contact #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] center_x,
	input  logic signed [31:0] center_y,
	input  logic [30:0]        radius,
	input  logic signed [31:0] box_left,
	input  logic signed [31:0] box_right,
	input  logic signed [31:0] box_bottom,
	input  logic signed [31:0] box_top,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] circle_point_x,
	output logic signed [31:0] circle_point_y,
	output logic signed [31:0] box_point_x,
	output logic signed [31:0] box_point_y,
	output logic signed [17:0] normal_x,
	output logic signed [17:0] normal_y,
	output logic signed [31:0] separation,
	output logic [2:0]         region,
	output logic               degenerate
);

	localparam int SQ = cbc_pkg::SQRT_STEPS;
	localparam int DV = cbc_pkg::DIV_BITS;
	localparam int NS = 3 + SQ + DV + 5;

	logic [NS-1:0] vld_q;
	logic          adv;

	assign adv      = !(out_stall && vld_q[NS-1]);
	assign in_stall = !adv;
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NS-2:0], in_valid};
		end
	end

	// ---------------- stage 1: classify
	cbc_pkg::geo_t      g_s1;
	logic [32:0]        a_s1, b_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			cbc_pkg::geo_t g;
			logic signed [32:0] sum, dx, dy, bxv, byv;
			logic [32:0] a, b;
			logic il, ib;
			g.cx     = center_x;
			g.cy     = center_y;
			g.r      = radius;
			g.degen  = 1'b0;
			g.nxneg  = 1'b0;
			g.nyneg  = 1'b0;
			g.corner = 1'b0;
			g.bx     = '0;
			g.by     = '0;
			g.region = cbc_pkg::RG_RIGHT;
			a = '0;
			b = '0;
			il = center_x < box_left;
			ib = center_y < box_bottom;
			if (box_right > center_x && box_left < center_x) begin
				sum = 33'(box_left) + 33'(box_right);
				g.bx = 32'(sum >>> 1);
				if (ib) begin
					g.region = cbc_pkg::RG_BOTTOM;
					g.by = box_bottom;
				end else begin
					g.region = cbc_pkg::RG_TOP;
					g.by = box_top;
					g.nyneg = 1'b1;
				end
			end else if (box_top > center_y && box_bottom < center_y) begin
				sum = 33'(box_bottom) + 33'(box_top);
				g.by = 32'(sum >>> 1);
				if (il) begin
					g.region = cbc_pkg::RG_LEFT;
					g.bx = box_left;
				end else begin
					g.region = cbc_pkg::RG_RIGHT;
					g.bx = box_right;
					g.nxneg = 1'b1;
				end
			end else begin
				g.corner = 1'b1;
				bxv = il ? 33'(box_left) : 33'(box_right);
				byv = ib ? 33'(box_bottom) : 33'(box_top);
				g.bx = 32'(bxv);
				g.by = 32'(byv);
				g.region = il ? (ib ? cbc_pkg::RG_BL : cbc_pkg::RG_TL)
				              : (ib ? cbc_pkg::RG_BR : cbc_pkg::RG_TR);
				dx = bxv - 33'(center_x);
				dy = byv - 33'(center_y);
				g.nxneg = dx[32];
				g.nyneg = dy[32];
				a = dx[32] ? 33'(-dx) : 33'(dx);
				b = dy[32] ? 33'(-dy) : 33'(dy);
				g.degen = (dx == 0) && (dy == 0);
			end
			g_s1 <= g;
			a_s1 <= a;
			b_s1 <= b;
		end
	end

	// ---------------- stage 2: leading-one position of max
	cbc_pkg::geo_t g_s2;
	logic [32:0]   a_s2, b_s2;
	logic [5:0]    lz_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			logic [32:0] m;
			logic [5:0]  p;
			m = (a_s1 > b_s1) ? a_s1 : b_s1;
			p = 6'd0;
			for (int i = 0; i < 33; i++) begin
				if (m[i]) p = 6'(i);
			end
			g_s2  <= g_s1;
			a_s2  <= a_s1;
			b_s2  <= b_s1;
			lz_s2 <= p;
		end
	end

	// ---------------- stage 3: normalize max into [2^30, 2^31)
	cbc_pkg::geo_t g_s3;
	logic [30:0]   a_s3, b_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			g_s3 <= g_s2;
			if (lz_s2 >= 6'd30) begin
				a_s3 <= 31'(a_s2 >> (lz_s2 - 6'd30));
				b_s3 <= 31'(b_s2 >> (lz_s2 - 6'd30));
			end else begin
				a_s3 <= 31'(a_s2 << (6'd30 - lz_s2));
				b_s3 <= 31'(b_s2 << (6'd30 - lz_s2));
			end
		end
	end

	// ---------------- square root: one result bit per stage
	cbc_pkg::geo_t g_sq [SQ+1];
	logic [30:0]   a_sq [SQ+1];
	logic [30:0]   b_sq [SQ+1];
	logic [63:0]   rem_sq [SQ+1];
	logic [31:0]   root_sq [SQ+1];
	logic [63:0]   s_sq [SQ+1];

	always_comb begin
		g_sq[0]    = g_s3;
		a_sq[0]    = a_s3;
		b_sq[0]    = b_s3;
		rem_sq[0]  = '0;
		root_sq[0] = '0;
		s_sq[0]    = 64'(a_s3) * 64'(a_s3) + 64'(b_s3) * 64'(b_s3);
	end

	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		always_ff @(posedge clk) begin
			if (adv) begin
				logic [65:0] rm, tr;
				rm = {rem_sq[k], s_sq[k][63:62]};
				tr = {32'd0, root_sq[k], 2'b01};
				g_sq[k+1] <= g_sq[k];
				a_sq[k+1] <= a_sq[k];
				b_sq[k+1] <= b_sq[k];
				s_sq[k+1] <= {s_sq[k][61:0], 2'b00};
				if (rm >= tr) begin
					rem_sq[k+1]  <= 64'(rm - tr);
					root_sq[k+1] <= {root_sq[k][30:0], 1'b1};
				end else begin
					rem_sq[k+1]  <= 64'(rm);
					root_sq[k+1] <= {root_sq[k][30:0], 1'b0};
				end
			end
		end
	end

	// ---------------- divide: (c << FRAC_BITS) + L/2 over L, one bit per stage
	localparam int NW = 31 + FRAC_BITS + 1;
	cbc_pkg::geo_t g_dv [DV+1];
	logic [31:0]   l_dv [DV+1];
	logic [NW-1:0] na_dv [DV+1];
	logic [NW-1:0] nb_dv [DV+1];
	logic [32:0]   ra_dv [DV+1];
	logic [32:0]   rb_dv [DV+1];
	logic [DV-1:0] qa_dv [DV+1];
	logic [DV-1:0] qb_dv [DV+1];

	always_comb begin
		logic [31:0] l;
		l = root_sq[SQ];
		g_dv[0]  = g_sq[SQ];
		l_dv[0]  = (l == 0) ? 32'd1 : l;
		na_dv[0] = (NW'(a_sq[SQ]) << FRAC_BITS) + NW'(l >> 1);
		nb_dv[0] = (NW'(b_sq[SQ]) << FRAC_BITS) + NW'(l >> 1);
		ra_dv[0] = 33'(na_dv[0] >> DV);
		rb_dv[0] = 33'(nb_dv[0] >> DV);
		qa_dv[0] = '0;
		qb_dv[0] = '0;
	end

	for (genvar k = 0; k < DV; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv) begin
				logic [33:0] ta, tb;
				ta = {ra_dv[k], na_dv[k][DV-1-k]};
				tb = {rb_dv[k], nb_dv[k][DV-1-k]};
				g_dv[k+1]  <= g_dv[k];
				l_dv[k+1]  <= l_dv[k];
				na_dv[k+1] <= na_dv[k];
				nb_dv[k+1] <= nb_dv[k];
				if (ta >= 34'(l_dv[k])) begin
					ra_dv[k+1] <= 33'(ta - 34'(l_dv[k]));
					qa_dv[k+1] <= {qa_dv[k][DV-2:0], 1'b1};
				end else begin
					ra_dv[k+1] <= 33'(ta);
					qa_dv[k+1] <= {qa_dv[k][DV-2:0], 1'b0};
				end
				if (tb >= 34'(l_dv[k])) begin
					rb_dv[k+1] <= 33'(tb - 34'(l_dv[k]));
					qb_dv[k+1] <= {qb_dv[k][DV-2:0], 1'b1};
				end else begin
					rb_dv[k+1] <= 33'(tb);
					qb_dv[k+1] <= {qb_dv[k][DV-2:0], 1'b0};
				end
			end
		end
	end

	// ---------------- tail stage 1: form signed normal
	cbc_pkg::geo_t      g_t1;
	logic signed [26:0] nx_t1, ny_t1;

	always_ff @(posedge clk) begin
		if (adv) begin
			logic [26:0] ma, mb, one;
			cbc_pkg::geo_t g;
			g   = g_dv[DV];
			one = 27'd1 << FRAC_BITS;
			if (!g.corner) begin
				ma = (g.region == cbc_pkg::RG_LEFT || g.region == cbc_pkg::RG_RIGHT) ?
				     one : 27'd0;
				mb = (g.region == cbc_pkg::RG_TOP || g.region == cbc_pkg::RG_BOTTOM) ?
				     one : 27'd0;
			end else if (g.degen) begin
				ma = '0;
				mb = '0;
			end else begin
				ma = 27'(qa_dv[DV]);
				mb = 27'(qb_dv[DV]);
			end
			g_t1  <= g;
			nx_t1 <= g.nxneg ? -$signed(ma) : $signed(ma);
			ny_t1 <= g.nyneg ? -$signed(mb) : $signed(mb);
		end
	end

	// ---------------- tail stage 2: radius products
	cbc_pkg::geo_t      g_t2;
	logic signed [26:0] nx_t2, ny_t2;
	logic signed [58:0] rx_t2, ry_t2;

	always_ff @(posedge clk) begin
		if (adv) begin
			g_t2  <= g_t1;
			nx_t2 <= nx_t1;
			ny_t2 <= ny_t1;
			rx_t2 <= $signed({28'd0, g_t1.r}) * 59'(nx_t1);
			ry_t2 <= $signed({28'd0, g_t1.r}) * 59'(ny_t1);
		end
	end

	function automatic logic signed [65:0] rdn(input logic signed [65:0] v);
		logic [65:0] m;
		m = v[65] ? 66'(-v) : 66'(v);
		m = (m + (66'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v[65] ? -$signed(m) : $signed(m);
	endfunction

	// ---------------- tail stage 3: circle point
	cbc_pkg::geo_t      g_t3;
	logic signed [26:0] nx_t3, ny_t3;
	logic signed [34:0] px_t3, py_t3;

	always_ff @(posedge clk) begin
		if (adv) begin
			g_t3  <= g_t2;
			nx_t3 <= nx_t2;
			ny_t3 <= ny_t2;
			px_t3 <= 35'(g_t2.cx) + 35'(rdn(66'(rx_t2)));
			py_t3 <= 35'(g_t2.cy) + 35'(rdn(66'(ry_t2)));
		end
	end

	// ---------------- tail stage 4: dot product terms
	cbc_pkg::geo_t      g_t4;
	logic signed [26:0] nx_t4, ny_t4;
	logic signed [34:0] px_t4, py_t4;
	logic signed [63:0] dx_t4, dy_t4;

	always_ff @(posedge clk) begin
		if (adv) begin
			g_t4  <= g_t3;
			nx_t4 <= nx_t3;
			ny_t4 <= ny_t3;
			px_t4 <= px_t3;
			py_t4 <= py_t3;
			dx_t4 <= 64'(35'(g_t3.bx) - px_t3) * 64'(nx_t3);
			dy_t4 <= 64'(35'(g_t3.by) - py_t3) * 64'(ny_t3);
		end
	end

	// ---------------- tail stage 5: output register
	always_ff @(posedge clk) begin
		if (adv) begin
			circle_point_x <= cbc_pkg::sat32(66'(px_t4));
			circle_point_y <= cbc_pkg::sat32(66'(py_t4));
			box_point_x    <= g_t4.bx;
			box_point_y    <= g_t4.by;
			normal_x       <= nx_t4[17:0];
			normal_y       <= ny_t4[17:0];
			separation     <= cbc_pkg::sat32(rdn(66'(dx_t4) + 66'(dy_t4)));
			region         <= g_t4.region;
			degenerate     <= g_t4.degen;
		end
	end

endmodule
